@@ hw/rtl/ctab_pkg.sv @@
package ctab_pkg;

    localparam int FUNC_W     = 3;
    localparam int OBJ_W      = 64;
    localparam int TYPE_W     = 8;
    localparam int RIGHTS_W   = 32;
    localparam int SLOT_IDX_W = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR      = 3'd0,
        FN_MINT       = 3'd1,
        FN_CHECK      = 3'd2,
        FN_REVOKE     = 3'd3,
        FN_REVOKE_ALL = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_MATCH  = 2'd2,
        ST_NO_RIGHTS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MINT,
        S_SCAN,
        S_REVOKE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [OBJ_W-1:0]    obj;
        logic [TYPE_W-1:0]   typ;
        logic [RIGHTS_W-1:0] rights;
    } t_entry;

    typedef struct packed {
        logic obj_eq;
        logic type_eq;
        logic rights_ok;
    } t_cmp_res;

endpackage

@@ hw/rtl/capability_table.sv @@
// capability_table: table of SLOTS capability slots (object, type, rights, valid).
//
// Input stream (s side): one request per handshake. tuser carries the operation
// (clear, mint, check, revoke slot, revoke all for object); tdata carries the
// object, type, rights and slot index. tready is high only while the sequencer
// is idle: one request at a time, the next taken once the result has moved to
// the output register.
// Output stream (m side): exactly one result per request (status, found_slot,
// live_count, revoked_count), held in an output register until taken.
//
// Clear and revoke go from their own state straight to the finish state; mint
// probes one valid bit per cycle and stops at the first free slot; check and
// revoke-all scan the table. The scan reads one slot per cycle from the slot memory
// (registered read) and feeds the single shared compare unit, so its length grows
// with the slot count; a check stops at its first match.
// A request may be accepted while the previous result still waits downstream;
// if the receiver stalls, the finished result holds in the sequencer until the
// output register frees, and no further request is taken meanwhile.
// Reset clears every valid bit and the live count; slot contents stay as they
// are and are read only behind a valid bit.
module capability_table #(
    parameter int SLOTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [63:0] object, [71:64] type, [103:72] cap_rights, [109:104] slot_index
    input  logic [ctab_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [2:0] func
    input  logic [ctab_pkg::FUNC_W-1:0]        i_s_tuser,
    // result
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] status, [7:2] found_slot, [14:8] live_count, [21:15] revoked_count
    output logic [ctab_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int CNT_W = ctab_pkg::COUNT_W;

    // request fields
    logic [ctab_pkg::OBJ_W-1:0]      s_obj;
    logic [ctab_pkg::TYPE_W-1:0]     s_type;
    logic [ctab_pkg::RIGHTS_W-1:0]   s_rights;
    logic [ctab_pkg::SLOT_IDX_W-1:0] s_sidx;
    logic                            s_accept;

    assign s_obj    = i_s_tdata[63:0];
    assign s_type   = i_s_tdata[71:64];
    assign s_rights = i_s_tdata[103:72];
    assign s_sidx   = i_s_tdata[109:104];
    assign s_accept = i_s_tvalid && o_s_tready;

    // latched request
    ctab_pkg::t_func                 r_func;
    logic [ctab_pkg::OBJ_W-1:0]      r_obj;
    logic [ctab_pkg::TYPE_W-1:0]     r_type;
    logic [ctab_pkg::RIGHTS_W-1:0]   r_rights;
    logic [ctab_pkg::SLOT_IDX_W-1:0] r_sidx;

    // control state
    ctab_pkg::t_state r_state, n_state;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [CNT_W-1:0] r_live, n_live;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_out_vld, n_out_vld;

    // result under construction
    ctab_pkg::t_status r_status, n_status;
    logic [IW-1:0]     r_found, n_found;
    logic [CNT_W-1:0]  r_revoked, n_revoked;
    logic [ctab_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    // slot memory and compare unit
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    ctab_pkg::t_entry  mem_wr_data;
    logic [IW-1:0]     mem_rd_addr;
    ctab_pkg::t_entry  mem_rd_data;
    ctab_pkg::t_cmp_res cmp_res;

    ctab_mem #(
        .SLOTS(SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    ctab_cmp u_cmp (
        .i_entry  (mem_rd_data),
        .i_obj    (r_obj),
        .i_type   (r_type),
        .i_rights (r_rights),
        .o_res    (cmp_res)
    );

    assign o_s_tready = (r_state == ctab_pkg::S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        logic out_free;
        logic issue;
        logic hit;

        n_state    = r_state;
        n_valid    = r_valid;
        n_live     = r_live;
        n_addr     = r_addr;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_status   = r_status;
        n_found    = r_found;
        n_revoked  = r_revoked;
        n_out_data = r_out_data;
        n_out_vld  = r_out_vld && !i_m_tready;

        mem_wr_en   = 1'b0;
        mem_wr_addr = r_addr[IW-1:0];
        mem_wr_data = '{obj: r_obj, typ: r_type, rights: r_rights};
        mem_rd_addr = r_addr[IW-1:0];

        out_free = !r_out_vld || i_m_tready;
        issue    = (r_addr != CW'(SLOTS));
        hit      = 1'b0;

        case (r_state)
            ctab_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_addr    = '0;
                    n_found   = '0;
                    n_revoked = '0;
                    n_status  = ctab_pkg::ST_OK;
                    case (ctab_pkg::t_func'(i_s_tuser))
                        ctab_pkg::FN_CLEAR: begin
                            n_state = ctab_pkg::S_CLEAR;
                        end
                        ctab_pkg::FN_MINT: begin
                            n_status = ctab_pkg::ST_FULL;
                            n_state  = ctab_pkg::S_MINT;
                        end
                        ctab_pkg::FN_CHECK: begin
                            n_status = ctab_pkg::ST_NO_MATCH;
                            n_state  = ctab_pkg::S_SCAN;
                        end
                        ctab_pkg::FN_REVOKE: begin
                            n_state = ctab_pkg::S_REVOKE;
                        end
                        ctab_pkg::FN_REVOKE_ALL: begin
                            n_state = ctab_pkg::S_SCAN;
                        end
                        default: begin
                            // unknown operation: report without touching the table
                            n_state = ctab_pkg::S_FIN;
                        end
                    endcase
                end
            end

            ctab_pkg::S_CLEAR: begin
                n_revoked = r_live;
                n_live    = '0;
                n_valid   = '0;
                n_state   = ctab_pkg::S_FIN;
            end

            ctab_pkg::S_REVOKE: begin
                if (({1'b0, r_sidx} < 7'(SLOTS)) && r_valid[r_sidx[IW-1:0]]) begin
                    n_valid[r_sidx[IW-1:0]] = 1'b0;
                    n_live    = r_live - CNT_W'(1);
                    n_revoked = CNT_W'(1);
                end
                n_state = ctab_pkg::S_FIN;
            end

            ctab_pkg::S_MINT: begin
                // probe one valid bit per cycle, lowest first
                if (!issue) begin
                    n_state = ctab_pkg::S_FIN;
                end else if (!r_valid[r_addr[IW-1:0]]) begin
                    mem_wr_en               = 1'b1;
                    n_valid[r_addr[IW-1:0]] = 1'b1;
                    n_live   = r_live + CNT_W'(1);
                    n_found  = r_addr[IW-1:0];
                    n_status = ctab_pkg::ST_OK;
                    n_state  = ctab_pkg::S_FIN;
                end else begin
                    n_addr = r_addr + CW'(1);
                end
            end

            ctab_pkg::S_SCAN: begin
                // issue stage: read the next slot
                if (issue) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_addr[IW-1:0];
                    n_addr    = r_addr + CW'(1);
                end
                // compare stage: slot read last cycle
                if (r_cmp_vld) begin
                    hit = r_valid[r_cmp_idx] && cmp_res.obj_eq &&
                          (cmp_res.type_eq || (r_func != ctab_pkg::FN_CHECK));
                end
                if (r_func == ctab_pkg::FN_CHECK) begin
                    if (hit) begin
                        n_found   = r_cmp_idx;
                        n_status  = cmp_res.rights_ok ? ctab_pkg::ST_OK
                                                      : ctab_pkg::ST_NO_RIGHTS;
                        n_cmp_vld = 1'b0;
                        n_state   = ctab_pkg::S_FIN;
                    end else if (!issue) begin
                        n_state = ctab_pkg::S_FIN;
                    end
                end else begin
                    if (hit) begin
                        n_valid[r_cmp_idx] = 1'b0;
                        n_live    = r_live - CNT_W'(1);
                        n_revoked = r_revoked + CNT_W'(1);
                    end
                    if (!issue) begin
                        n_state = ctab_pkg::S_FIN;
                    end
                end
            end

            ctab_pkg::S_FIN: begin
                // hold the result until the output register frees
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {2'b00, r_revoked, r_live,
                                  ctab_pkg::SLOT_IDX_W'(r_found), r_status};
                    n_state    = ctab_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ctab_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ctab_pkg::S_IDLE;
            r_valid   <= '0;
            r_live    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_live    <= n_live;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_cmp_idx  <= n_cmp_idx;
        r_status   <= n_status;
        r_found    <= n_found;
        r_revoked  <= n_revoked;
        r_out_data <= n_out_data;
        if (s_accept) begin
            r_func   <= ctab_pkg::t_func'(i_s_tuser);
            r_obj    <= s_obj;
            r_type   <= s_type;
            r_rights <= s_rights;
            r_sidx   <= s_sidx;
        end
    end

endmodule

@@ hw/rtl/ctab_mem.sv @@
module ctab_mem #(
    parameter int SLOTS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] i_wr_addr,
    input  ctab_pkg::t_entry                     i_wr_data,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] i_rd_addr,
    output ctab_pkg::t_entry                     o_rd_data
);

    ctab_pkg::t_entry r_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

@@ hw/rtl/ctab_cmp.sv @@
module ctab_cmp (
    input  ctab_pkg::t_entry                     i_entry,
    input  logic [ctab_pkg::OBJ_W-1:0]           i_obj,
    input  logic [ctab_pkg::TYPE_W-1:0]          i_type,
    input  logic [ctab_pkg::RIGHTS_W-1:0]        i_rights,
    output ctab_pkg::t_cmp_res                   o_res
);

    always_comb begin
        o_res.obj_eq    = (i_entry.obj == i_obj);
        o_res.type_eq   = (i_entry.typ == i_type);
        // every required bit must be granted
        o_res.rights_ok = ((i_entry.rights & i_rights) == i_rights);
    end

endmodule
